### src/ptdq_pkg.sv
`timescale 1ns / 1ps

package ptdq_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TICK_BITS_DEF = 16;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_COMPLETE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TK_CHK,
      ST_TK_PER,
      ST_TK_HEAD,
      ST_TK_LAST,
      ST_INS_START,
      ST_INS_CHK,
      ST_INS_SUCC,
      ST_INS_LINK,
      ST_RM_CHK,
      ST_RM_SUCC,
      ST_RM_LINK
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  task_id;
      logic [15:0] period_ticks;
   } req_type;

   typedef struct packed {
      logic [3:0] expired_task;
      logic       released;
      logic       last;
   } rsp_type;

endpackage

### src/ptdq_store.sv
`timescale 1ns / 1ps

// Link store {next, delta} and period store, one write and one registered read each.
module ptdq_store #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4,
   parameter int ENT_W = 22,
   parameter int PER_W = 16
) (
   input  logic             clock,
   input  logic             ent_rd_en,
   input  logic [IDX_W-1:0] ent_rd_addr,
   output logic [ENT_W-1:0] ent_rd_data,
   input  logic             ent_wr_en,
   input  logic [IDX_W-1:0] ent_wr_addr,
   input  logic [ENT_W-1:0] ent_wr_data,
   input  logic             per_rd_en,
   input  logic [IDX_W-1:0] per_rd_addr,
   output logic [PER_W-1:0] per_rd_data,
   input  logic             per_wr_en,
   input  logic [IDX_W-1:0] per_wr_addr,
   input  logic [PER_W-1:0] per_wr_data
);

   logic [ENT_W-1:0] ent_mem [DEPTH];
   logic [PER_W-1:0] per_mem [DEPTH];
   logic [ENT_W-1:0] ent_q_ff;
   logic [PER_W-1:0] per_q_ff;

   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      if (ent_rd_en) begin
         ent_q_ff <= ent_mem[ent_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (per_wr_en) begin
         per_mem[per_wr_addr] <= per_wr_data;
      end
      if (per_rd_en) begin
         per_q_ff <= per_mem[per_rd_addr];
      end
   end

   assign ent_rd_data = ent_q_ff;
   assign per_rd_data = per_q_ff;

endmodule

### src/periodic_task_delta_queue.sv
`timescale 1ns / 1ps
// Complete only updates an idle flag; add and remove walk the list entry by entry.
// Tick checks the head entry; each expired task is popped and reinserted by the same list walk.
// Throughput: one beat at a time; a list walk takes one link-store read per cycle.
// Results leave through an output register; the last one goes out once the chain ends.
// Reset (synchronous): list empty, all queued and idle flags clear; stores hold junk.

module periodic_task_delta_queue #(
   parameter int MAX_TASKS = ptdq_pkg::MAX_TASKS_DEF,
   parameter int TICK_BITS = ptdq_pkg::TICK_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptdq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptdq_pkg::rsp_type rsp_data
);

   // Entry = {next pointer, delta}. Pointer MSB set means null.
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int PW = IW + 1;
   localparam int DW = TICK_BITS + 1;
   localparam int EW = PW + DW;
   localparam logic [PW-1:0] NIL_PTR = {1'b1, {IW{1'b0}}};

   ptdq_pkg::state_type state_ff, state_in;

   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        cur_ff, cur_in;
   logic [PW-1:0]        prev_ff, prev_in;
   logic [DW-1:0]        prev_delta_ff, prev_delta_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [IW-1:0]        id_ff, id_in;
   logic                 first_ff, first_in;
   logic                 ret_tick_ff, ret_tick_in;
   logic [MAX_TASKS-1:0] inq_ff, inq_in;
   logic [MAX_TASKS-1:0] idle_ff, idle_in;

   // One expiry result is held back until we know whether it is the last of the tick.
   logic                 pend_valid_ff, pend_valid_in;
   logic [3:0]           pend_task_ff, pend_task_in;
   logic                 pend_rel_ff, pend_rel_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   ptdq_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // store ports
   logic                 ent_rd_en, ent_wr_en, per_rd_en, per_wr_en;
   logic [IW-1:0]        ent_rd_addr, ent_wr_addr, per_rd_addr, per_wr_addr;
   logic [EW-1:0]        ent_rd_data, ent_wr_data;
   logic [TICK_BITS-1:0] per_rd_data, per_wr_data;

   logic [PW-1:0]        rd_next;
   logic [DW-1:0]        rd_delta;
   logic [DW-1:0]        eff_delta;
   logic [DW-1:0]        rem_sub;
   logic                 pop;
   logic                 slot_free;
   logic                 req_id_ok;
   logic [IW-1:0]        req_idx;
   logic [IW-1:0]        cur_idx;
   logic [32:0]          per_w;
   logic [32:0]          per_sat;
   logic [32:0]          pmax_w;

   assign rd_next   = ent_rd_data[EW-1:DW];
   assign rd_delta  = ent_rd_data[DW-1:0];
   assign cur_idx   = cur_ff[IW-1:0];
   assign eff_delta = first_ff ? (rd_delta - DW'(1)) : rd_delta;
   // head delta is at least one before the tick, so zero (or a wrap) means expired
   assign pop       = (eff_delta == '0) || eff_delta[DW-1];
   assign rem_sub   = rem_ff - rd_delta;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign req_id_ok = 32'(req_data.task_id) < 32'(MAX_TASKS);
   assign req_idx   = IW'(req_data.task_id);

   // period saturation: 0 -> 1, above the tick range -> max
   assign pmax_w  = (33'd1 << TICK_BITS) - 33'd1;
   assign per_w   = (req_data.period_ticks == 16'd0) ? 33'd1 : 33'(req_data.period_ticks);
   assign per_sat = (per_w > pmax_w) ? pmax_w : per_w;

   ptdq_store #(
      .DEPTH (MAX_TASKS),
      .IDX_W (IW),
      .ENT_W (EW),
      .PER_W (TICK_BITS)
   ) u_store (
      .clock       (clock),
      .ent_rd_en   (ent_rd_en),
      .ent_rd_addr (ent_rd_addr),
      .ent_rd_data (ent_rd_data),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data),
      .per_rd_en   (per_rd_en),
      .per_rd_addr (per_rd_addr),
      .per_rd_data (per_rd_data),
      .per_wr_en   (per_wr_en),
      .per_wr_addr (per_wr_addr),
      .per_wr_data (per_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptdq_pkg::ST_IDLE;
         head_ff       <= NIL_PTR;
         inq_ff        <= '0;
         idle_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         first_ff      <= 1'b0;
         ret_tick_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         inq_ff        <= inq_in;
         idle_ff       <= idle_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         first_ff      <= first_in;
         ret_tick_ff   <= ret_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_delta_ff <= prev_delta_in;
      rem_ff        <= rem_in;
      id_ff         <= id_in;
      pend_task_ff  <= pend_task_in;
      pend_rel_ff   <= pend_rel_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_delta_in = prev_delta_ff;
      rem_in        = rem_ff;
      id_in         = id_ff;
      first_in      = first_ff;
      ret_tick_in   = ret_tick_ff;
      inq_in        = inq_ff;
      idle_in       = idle_ff;
      pend_valid_in = pend_valid_ff;
      pend_task_in  = pend_task_ff;
      pend_rel_in   = pend_rel_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      ent_rd_en   = 1'b0;
      ent_rd_addr = head_ff[IW-1:0];
      ent_wr_en   = 1'b0;
      ent_wr_addr = id_ff;
      ent_wr_data = {NIL_PTR, rem_ff};
      per_rd_en   = 1'b0;
      per_rd_addr = cur_idx;
      per_wr_en   = 1'b0;
      per_wr_addr = req_idx;
      per_wr_data = TICK_BITS'(per_sat);

      case (state_ff)
         ptdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.operation)
                  ptdq_pkg::OP_TICK: begin
                     if (!head_ff[IW]) begin
                        ent_rd_en = 1'b1;
                        cur_in    = head_ff;
                        first_in  = 1'b1;
                        state_in  = ptdq_pkg::ST_TK_CHK;
                     end
                  end
                  ptdq_pkg::OP_ADD: begin
                     if (req_id_ok && !inq_ff[req_idx]) begin
                        per_wr_en        = 1'b1;
                        idle_in[req_idx] = 1'b0;
                        id_in            = req_idx;
                        rem_in           = DW'(per_sat);
                        ret_tick_in      = 1'b0;
                        state_in         = ptdq_pkg::ST_INS_START;
                     end
                  end
                  ptdq_pkg::OP_REMOVE: begin
                     if (req_id_ok && inq_ff[req_idx]) begin
                        ent_rd_en = 1'b1;
                        cur_in    = head_ff;
                        prev_in   = NIL_PTR;
                        id_in     = req_idx;
                        state_in  = ptdq_pkg::ST_RM_CHK;
                     end
                  end
                  ptdq_pkg::OP_COMPLETE: begin
                     if (req_id_ok) begin
                        idle_in[req_idx] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // head entry in the read register; decrement only on the first look
         ptdq_pkg::ST_TK_CHK: begin
            if (pop) begin
               if (!pend_valid_ff || slot_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.expired_task = pend_task_ff;
                     rsp_data_in.released     = pend_rel_ff;
                     rsp_data_in.last         = 1'b0;
                  end
                  head_in          = rd_next;
                  inq_in[cur_idx]  = 1'b0;
                  pend_valid_in    = 1'b1;
                  pend_task_in     = 4'(cur_idx);
                  pend_rel_in      = idle_ff[cur_idx];
                  idle_in[cur_idx] = 1'b0;
                  per_rd_en        = 1'b1;
                  id_in            = cur_idx;
                  first_in         = 1'b0;
                  state_in         = ptdq_pkg::ST_TK_PER;
               end
            end else begin
               if (first_ff) begin
                  ent_wr_en   = 1'b1;
                  ent_wr_addr = cur_idx;
                  ent_wr_data = {rd_next, eff_delta};
               end
               first_in = 1'b0;
               state_in = pend_valid_ff ? ptdq_pkg::ST_TK_LAST : ptdq_pkg::ST_IDLE;
            end
         end

         ptdq_pkg::ST_TK_PER: begin
            rem_in      = DW'(per_rd_data);
            ret_tick_in = 1'b1;
            state_in    = ptdq_pkg::ST_INS_START;
         end

         ptdq_pkg::ST_TK_HEAD: begin
            ent_rd_en = 1'b1;
            cur_in    = head_ff;
            state_in  = ptdq_pkg::ST_TK_CHK;
         end

         ptdq_pkg::ST_TK_LAST: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.expired_task = pend_task_ff;
               rsp_data_in.released     = pend_rel_ff;
               rsp_data_in.last         = 1'b1;
               pend_valid_in            = 1'b0;
               state_in                 = ptdq_pkg::ST_IDLE;
            end
         end

         ptdq_pkg::ST_INS_START: begin
            if (head_ff[IW]) begin
               ent_wr_en     = 1'b1;
               ent_wr_data   = {NIL_PTR, rem_ff};
               head_in       = {1'b0, id_ff};
               inq_in[id_ff] = 1'b1;
               state_in      = ret_tick_ff ? ptdq_pkg::ST_TK_HEAD : ptdq_pkg::ST_IDLE;
            end else begin
               ent_rd_en = 1'b1;
               cur_in    = head_ff;
               prev_in   = NIL_PTR;
               state_in  = ptdq_pkg::ST_INS_CHK;
            end
         end

         // walk: stop before the first entry whose cumulative delay exceeds the period
         ptdq_pkg::ST_INS_CHK: begin
            if (rem_ff < rd_delta) begin
               ent_wr_en   = 1'b1;
               ent_wr_data = {cur_ff, rem_ff};
               state_in    = ptdq_pkg::ST_INS_SUCC;
            end else begin
               rem_in        = rem_sub;
               prev_in       = cur_ff;
               prev_delta_in = rd_delta;
               if (rd_next[IW]) begin
                  ent_wr_en   = 1'b1;
                  ent_wr_data = {NIL_PTR, rem_sub};
                  cur_in      = NIL_PTR;
                  state_in    = ptdq_pkg::ST_INS_LINK;
               end else begin
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = rd_next[IW-1:0];
                  cur_in      = rd_next;
               end
            end
         end

         ptdq_pkg::ST_INS_SUCC: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = cur_idx;
            ent_wr_data = {rd_next, rd_delta - rem_ff};
            state_in    = ptdq_pkg::ST_INS_LINK;
         end

         ptdq_pkg::ST_INS_LINK: begin
            if (prev_ff[IW]) begin
               head_in = {1'b0, id_ff};
            end else begin
               ent_wr_en   = 1'b1;
               ent_wr_addr = prev_ff[IW-1:0];
               ent_wr_data = {1'b0, id_ff, prev_delta_ff};
            end
            inq_in[id_ff] = 1'b1;
            state_in      = ret_tick_ff ? ptdq_pkg::ST_TK_HEAD : ptdq_pkg::ST_IDLE;
         end

         ptdq_pkg::ST_RM_CHK: begin
            if (cur_ff == {1'b0, id_ff}) begin
               cur_in = rd_next;
               rem_in = rd_delta;
               if (!rd_next[IW]) begin
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = rd_next[IW-1:0];
                  state_in    = ptdq_pkg::ST_RM_SUCC;
               end else begin
                  state_in = ptdq_pkg::ST_RM_LINK;
               end
            end else begin
               prev_in       = cur_ff;
               prev_delta_in = rd_delta;
               cur_in        = rd_next;
               ent_rd_en     = 1'b1;
               ent_rd_addr   = rd_next[IW-1:0];
            end
         end

         ptdq_pkg::ST_RM_SUCC: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = cur_idx;
            ent_wr_data = {rd_next, rd_delta + rem_ff};
            state_in    = ptdq_pkg::ST_RM_LINK;
         end

         ptdq_pkg::ST_RM_LINK: begin
            if (prev_ff[IW]) begin
               head_in = cur_ff;
            end else begin
               ent_wr_en   = 1'b1;
               ent_wr_addr = prev_ff[IW-1:0];
               ent_wr_data = {cur_ff, prev_delta_ff};
            end
            inq_in[id_ff] = 1'b0;
            state_in      = ptdq_pkg::ST_IDLE;
         end

         default: state_in = ptdq_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ptdq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a held-back result never outlives its tick
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptdq_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("expiry result left pending in idle");

   // sequencing keeps link-store reads and writes in separate cycles
   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(ent_rd_en && ent_wr_en))
      else $error("link store read and write in one cycle");

   // after a reinsertion the list cannot be empty
   a_head_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptdq_pkg::ST_TK_HEAD |-> !head_ff[IW])
      else $error("empty list after reinsertion");

   // a popped task is queued again before the next head check
   a_requeue: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptdq_pkg::ST_TK_HEAD |-> inq_ff[id_ff])
      else $error("reinserted task not marked queued");
`endif

endmodule

### tb/periodic_task_delta_queue_tb.sv
`timescale 1ns / 1ps

module periodic_task_delta_queue_tb;

   localparam int NUM_TASKS     = 16;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_BEATS  = 500;
   localparam int NO_TASK       = -1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ptdq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ptdq_pkg::rsp_type rsp_data;

   periodic_task_delta_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the timer list.
   int          list_head;
   int          link_next [NUM_TASKS];
   longint      delta_left [NUM_TASKS];
   int unsigned task_period [NUM_TASKS];
   bit          queued [NUM_TASKS];
   bit          idle [NUM_TASKS];

   ptdq_pkg::rsp_type expiry_queue[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          hold_long = 1'b0;

   // Walk past every entry whose cumulative delay is <= the period.
   task automatic list_insert(input int id, input longint period);
      longint rem;
      int     prev;
      int     cur;
      int     guard;
      rem   = period;
      prev  = NO_TASK;
      cur   = list_head;
      guard = 0;
      while (cur != NO_TASK && guard < NUM_TASKS) begin
         if (rem - delta_left[cur] < 0) break;
         rem  -= delta_left[cur];
         prev  = cur;
         cur   = link_next[cur];
         guard++;
      end
      delta_left[id] = rem;
      link_next[id]  = cur;
      if (prev == NO_TASK) list_head = id;
      else link_next[prev] = id;
      if (cur != NO_TASK) delta_left[cur] -= rem;
      queued[id] = 1'b1;
   endtask

   task automatic list_unlink(input int id);
      int prev;
      int cur;
      int guard;
      prev  = NO_TASK;
      cur   = list_head;
      guard = 0;
      while (cur != NO_TASK && cur != id && guard < NUM_TASKS) begin
         prev = cur;
         cur  = link_next[cur];
         guard++;
      end
      if (cur != id) return;
      if (link_next[id] != NO_TASK) delta_left[link_next[id]] += delta_left[id];
      if (prev == NO_TASK) list_head = link_next[id];
      else link_next[prev] = link_next[id];
      queued[id] = 1'b0;
   endtask

   // Apply one accepted beat; expiries go to expiry_queue. Returns count.
   task automatic apply_beat(input ptdq_pkg::req_type beat, output int n_expired);
      int                id;
      int unsigned       per;
      int                t;
      ptdq_pkg::rsp_type r;
      id        = beat.task_id;
      n_expired = 0;
      case (ptdq_pkg::op_type'(beat.operation))
         ptdq_pkg::OP_TICK: begin
            if (list_head != NO_TASK) begin
               delta_left[list_head] -= 1;
               while (list_head != NO_TASK && delta_left[list_head] <= 0
                      && n_expired < NUM_TASKS) begin
                  t = list_head;
                  list_head = link_next[t];
                  queued[t] = 1'b0;
                  r.expired_task = t[3:0];
                  r.released     = idle[t];
                  r.last         = 1'b0;
                  idle[t] = 1'b0;
                  list_insert(t, task_period[t]);
                  expiry_queue.push_back(r);
                  n_expired++;
               end
               if (n_expired > 0) expiry_queue[$].last = 1'b1;
            end
         end
         ptdq_pkg::OP_ADD: begin
            if (!queued[id]) begin
               per = beat.period_ticks;
               if (per == 0) per = 1;
               task_period[id] = per;
               idle[id] = 1'b0;
               list_insert(id, per);
            end
         end
         ptdq_pkg::OP_REMOVE: begin
            if (queued[id]) list_unlink(id);
         end
         default: idle[id] = 1'b1;
      endcase
   endtask

   function automatic ptdq_pkg::req_type mk(ptdq_pkg::op_type op, int id, int per);
      ptdq_pkg::req_type b;
      b.operation    = op;
      b.task_id      = id[3:0];
      b.period_ticks = per[15:0];
      return b;
   endfunction

   function automatic int short_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Directed rows: a typed expectation is given where it is obvious.
   typedef struct {
      ptdq_pkg::req_type beat;
      int                n_typed;       // -1: predictor only
      ptdq_pkg::rsp_type typed_rsp;
   } dir_row_type;

   dir_row_type dir_rows[$];

   task automatic add_row(ptdq_pkg::req_type b, int n_typed, ptdq_pkg::rsp_type r);
      dir_row_type d;
      d.beat = b; d.n_typed = n_typed; d.typed_rsp = r;
      dir_rows.push_back(d);
   endtask

   // Sender: one beat, waits for acceptance, updates predictor.
   // Valid drops only when a gap follows, so back-to-back beats keep it high.
   task automatic send_beat(input ptdq_pkg::req_type b, output int n_expired);
      int gap;
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_beat(b, n_expired);
      gap = short_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: random stall, with one long hold-off during pressure.
   int hold_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_long && hold_cycles < 400) begin
         hold_cycles <= hold_cycles + 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 :
                      ($urandom_range(0, 49) == 0 ? 1'b1 : 1'b0);
      end
   end

   // Checker: compare each accepted result beat against oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expiry_queue.size() == 0) begin
            $error("unexpected result beat: task %0d", rsp_data.expired_task);
            error_count++;
         end else begin
            ptdq_pkg::rsp_type e;
            e = expiry_queue.pop_front();
            if (rsp_data.expired_task !== e.expired_task) begin
               $error("expired_task exp %0d got %0d", e.expired_task,
                      rsp_data.expired_task);
               error_count++;
            end
            if (rsp_data.released !== e.released) begin
               $error("released exp %0d got %0d", e.released, rsp_data.released);
               error_count++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Run-away guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("periodic_task_delta_queue_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int                n;
      int                k;
      int                id;
      int                sel;
      ptdq_pkg::rsp_type none;
      none = '0;

      list_head = NO_TASK;
      for (int i = 0; i < NUM_TASKS; i++) begin
         link_next[i] = NO_TASK; delta_left[i] = 0; task_period[i] = 0;
         queued[i] = 0; idle[i] = 0;
      end

      // Tick on empty list, then extremes and every operation.
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), 0, none);
      add_row(mk(ptdq_pkg::OP_ADD, 0, 0), 0, none);          // zero period -> 1
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), 1, '{4'd0, 1'b0, 1'b1});  // overrun
      add_row(mk(ptdq_pkg::OP_COMPLETE, 0, 0), 0, none);
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), 1, '{4'd0, 1'b1, 1'b1});  // released
      add_row(mk(ptdq_pkg::OP_ADD, 0, 5), 0, none);          // already queued, ignored
      add_row(mk(ptdq_pkg::OP_REMOVE, 0, 0), 0, none);
      add_row(mk(ptdq_pkg::OP_REMOVE, 0, 0), 0, none);       // absent, ignored
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), 0, none);
      add_row(mk(ptdq_pkg::OP_ADD, 15, 65535), 0, none);
      add_row(mk(ptdq_pkg::OP_ADD, 5, 2), 0, none);
      add_row(mk(ptdq_pkg::OP_ADD, 6, 2), 0, none);          // equal delay goes behind
      add_row(mk(ptdq_pkg::OP_ADD, 7, 3), 0, none);
      add_row(mk(ptdq_pkg::OP_COMPLETE, 6, 0), 0, none);
      add_row(mk(ptdq_pkg::OP_COMPLETE, 9, 0), 0, none);     // complete of absent task
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), 0, none);         // nothing expires
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), -1, none);        // two expire
      add_row(mk(ptdq_pkg::OP_REMOVE, 7, 0), -1, none);
      add_row(mk(ptdq_pkg::OP_TICK, 0, 0), -1, none);
      add_row(mk(ptdq_pkg::OP_REMOVE, 15, 0), -1, none);
      add_row(mk(ptdq_pkg::OP_REMOVE, 5, 0), -1, none);
      add_row(mk(ptdq_pkg::OP_REMOVE, 6, 0), -1, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].beat, n);
         if (dir_rows[i].n_typed >= 0) begin
            if (n != dir_rows[i].n_typed) begin
               $error("row %0d: result count exp %0d got %0d", i,
                      dir_rows[i].n_typed, n);
               error_count++;
            end else if (n == 1 && expiry_queue[$] != dir_rows[i].typed_rsp) begin
               $error("row %0d: typed expectation differs from predictor", i);
               error_count++;
            end
         end
      end

      // Random: mostly adds with short periods and ticks, so tasks expire.
      for (k = 0; k < RANDOM_BEATS; k++) begin
         if (k == RANDOM_BEATS / 2) hold_long = 1'b1;   // long back-pressure
         sel = $urandom_range(0, 99);
         id  = $urandom_range(0, 15);
         if (sel < 30)
            send_beat(mk(ptdq_pkg::OP_ADD, id, ($urandom_range(0, 19) == 0) ?
                         $urandom_range(0, 65535) : $urandom_range(0, 6)), n);
         else if (sel < 70)
            send_beat(mk(ptdq_pkg::OP_TICK, id, $urandom_range(0, 65535)), n);
         else if (sel < 80)
            send_beat(mk(ptdq_pkg::OP_REMOVE, id, $urandom_range(0, 65535)), n);
         else
            send_beat(mk(ptdq_pkg::OP_COMPLETE, id, $urandom_range(0, 65535)), n);
      end
      req_valid <= 1'b0;

      while (expiry_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (error_count == 0 && expiry_queue.size() == 0)
         $display("periodic_task_delta_queue_tb: PASS");
      else
         $display("periodic_task_delta_queue_tb: FAIL");
      $finish;
   end

endmodule
